// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define AIT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ait: same-cycle check failed");

// Next-cycle implication, quiet while reset is held.
`define AIT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ait: next-cycle check failed");

`endif

// ===== hdl/ait_pkg.sv =====
package ait_pkg;

  // Field and datapath widths
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DIM_W   = 9;
  localparam int unsigned SCALE_W = 17;
  localparam int unsigned SUM_W   = 24;
  localparam int unsigned CRD_W   = 10;
  localparam int unsigned SPAN_W  = 6;
  localparam int unsigned CNT_W   = 2 * SPAN_W;
  localparam int unsigned PROD_W  = PIX_W + CNT_W;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned LHS_W   = PROD_W + FRAC_W;
  localparam int unsigned RHS_W   = SUM_W + SCALE_W;
  localparam int unsigned HALF_SH = 4;

  // Register port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [DIM_W-1:0]   DIM_RST   = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RST = 17'd55706;
  localparam logic [PIX_W-1:0]   PIX_DARK  = 8'd0;
  localparam logic [PIX_W-1:0]   PIX_LIGHT = 8'd255;

  typedef enum logic {
    OP_LOAD,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NOT_LOADED,
    STAT_OUTSIDE
  } status_t;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_SCALE
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_WR,
    ST_Q_RD0,
    ST_Q_RD1,
    ST_Q_RD2,
    ST_Q_RD3,
    ST_Q_ACC,
    ST_Q_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    status_t          status;
  } out_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [SCALE_W-1:0] scale;
    logic               restart;
  } cfg_t;

  // Map a written dimension into 1..maxv
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// ===== hdl/ait_cfg.sv =====
module ait_cfg #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ait_pkg::APB_AW-1:0] paddr,
  input  logic [ait_pkg::APB_DW-1:0] pwdata,
  output logic [ait_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output ait_pkg::cfg_t              cfg
);
  import ait_pkg::*;

  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [SCALE_W-1:0] scale_r;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  // Take a register write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_dim(DIM_RST, MAX_WIDTH);
      height_r <= clamp_dim(DIM_RST, MAX_HEIGHT);
      scale_r  <= SCALE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_r  <= clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH);
        REG_HEIGHT: height_r <= clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT);
        REG_SCALE:  scale_r  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the register value on a read
  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = APB_DW'(width_r);
      REG_HEIGHT: prdata = APB_DW'(height_r);
      REG_SCALE:  prdata = APB_DW'(scale_r);
      default:    prdata = '0;
    endcase
  end

  // A dimension write restarts loading
  always_comb begin
    cfg.width   = width_r;
    cfg.height  = height_r;
    cfg.scale   = scale_r;
    cfg.restart = wr_en && (idx == REG_WIDTH || idx == REG_HEIGHT);
  end

endmodule

// ===== hdl/ait_store.sv =====
module ait_store #(
  parameter int unsigned AW = 16
) (
  input  logic                      clk,
  input  logic [AW-1:0]             pix_addr,
  input  logic                      pix_we,
  input  logic                      pix_re,
  input  logic [ait_pkg::PIX_W-1:0] pix_wdata,
  output logic [ait_pkg::PIX_W-1:0] pix_rdata,
  input  logic [AW-1:0]             sum_addr,
  input  logic                      sum_we,
  input  logic                      sum_re,
  input  logic [ait_pkg::SUM_W-1:0] sum_wdata,
  output logic [ait_pkg::SUM_W-1:0] sum_rdata
);
  import ait_pkg::*;

  // Pixel store and summed-area table without its zero border
  logic [PIX_W-1:0] pix_mem [0:(2**AW)-1];
  logic [SUM_W-1:0] sum_mem [0:(2**AW)-1];
  logic [PIX_W-1:0] pix_rdata_r;
  logic [SUM_W-1:0] sum_rdata_r;

  always_ff @(posedge clk) begin
    if (pix_we) begin
      pix_mem[pix_addr] <= pix_wdata;
    end
    if (pix_re) begin
      pix_rdata_r <= pix_mem[pix_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_addr] <= sum_wdata;
    end
    if (sum_re) begin
      sum_rdata_r <= sum_mem[sum_addr];
    end
  end

  assign pix_rdata = pix_rdata_r;
  assign sum_rdata = sum_rdata_r;

endmodule

// ===== hdl/ait_ctrl.sv =====
module ait_ctrl #(
  parameter  int unsigned MAX_WIDTH  = 256,
  parameter  int unsigned MAX_HEIGHT = 256,
  localparam int unsigned CW         = $clog2(MAX_WIDTH),
  localparam int unsigned RW         = $clog2(MAX_HEIGHT),
  localparam int unsigned AW         = CW + RW
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ait_pkg::in_item_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ait_pkg::out_item_t        out_data,
  input  ait_pkg::cfg_t             cfg,
  output logic [AW-1:0]             pix_addr,
  output logic                      pix_we,
  output logic                      pix_re,
  output logic [ait_pkg::PIX_W-1:0] pix_wdata,
  input  logic [ait_pkg::PIX_W-1:0] pix_rdata,
  output logic [AW-1:0]             sum_addr,
  output logic                      sum_we,
  output logic                      sum_re,
  output logic [ait_pkg::SUM_W-1:0] sum_wdata,
  input  logic [ait_pkg::SUM_W-1:0] sum_rdata
);
  import ait_pkg::*;

  localparam int unsigned RSW = $clog2(MAX_WIDTH * 255 + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    load_col_r, load_col_nxt;
  logic [RW-1:0]    load_row_r, load_row_nxt;
  logic [RSW-1:0]   row_sum_r, row_sum_nxt;
  logic             complete_r, complete_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             out_load;

  status_t          status_r, status_nxt;
  logic [CW-1:0]    qx1_r, qx2_r;
  logic [RW-1:0]    qy1_r, qy2_r;
  logic             zero_r, zero_nxt;
  logic [SUM_W-1:0] acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PROD_W-1:0] prod_r;
  logic [RHS_W-1:0] rhs_r;

  logic             accept;
  logic             ld_accept;
  logic             q_accept;
  logic [DIM_W-1:0] dim_max;
  logic [CRD_W-1:0] half;
  logic [CRD_W-1:0] qc, qr, w_c, h_c;
  logic [CRD_W-1:0] x1, x2, y1, y2;
  logic             outside;
  logic [CW-1:0]    cx;
  logic [RW-1:0]    cy;
  logic [SUM_W-1:0] sum_rd;
  logic [SPAN_W-1:0] span_x, span_y;
  logic [LHS_W-1:0] lhs;
  logic             col_last, row_last;

  assign accept    = in_valid && in_ready;
  assign ld_accept = accept && (in_data.op == OP_LOAD);
  assign q_accept  = accept && (in_data.op == OP_QUERY);

  // Window bounds from the query position, clamped at the image edges, and the query status
  always_comb begin
    dim_max = (cfg.width > cfg.height) ? cfg.width : cfg.height;
    half    = CRD_W'(dim_max >> HALF_SH);
    qc      = CRD_W'(in_data.col);
    qr      = CRD_W'(in_data.row);
    w_c     = CRD_W'(cfg.width);
    h_c     = CRD_W'(cfg.height);
    x1      = (qc >= half) ? qc - half : '0;
    y1      = (qr >= half) ? qr - half : '0;
    x2      = (qc + half >= w_c) ? w_c - CRD_W'(1) : qc + half;
    y2      = (qr + half >= h_c) ? h_c - CRD_W'(1) : qr + half;
    outside = (qc >= w_c) || (qr >= h_c);
    if (!complete_r) begin
      status_nxt = STAT_NOT_LOADED;
    end else if (outside) begin
      status_nxt = STAT_OUTSIDE;
    end else begin
      status_nxt = STAT_OK;
    end
  end

  // Pick the table corner for this read cycle
  always_comb begin
    case (state_r)
      ST_Q_RD0: begin cy = qy2_r; cx = qx2_r; end
      ST_Q_RD1: begin cy = qy1_r; cx = qx2_r; end
      ST_Q_RD2: begin cy = qy2_r; cx = qx1_r; end
      default:  begin cy = qy1_r; cx = qx1_r; end
    endcase
  end

  // Border entries of the table read as zero
  assign sum_rd   = zero_r ? '0 : sum_rdata;
  assign span_x   = SPAN_W'(qx2_r - qx1_r);
  assign span_y   = SPAN_W'(qy2_r - qy1_r);
  assign lhs      = {prod_r, FRAC_W'(0)};
  assign col_last = (CRD_W'(load_col_r) + CRD_W'(1)) >= w_c;
  assign row_last = (CRD_W'(load_row_r) + CRD_W'(1)) >= h_c;

  // Memory ports: pixel write on load, pixel read on a query inside a complete image
  always_comb begin
    pix_we    = ld_accept;
    pix_re    = q_accept && (status_nxt == STAT_OK);
    pix_wdata = in_data.pixel;
    pix_addr  = ld_accept ? {load_row_r, load_col_r} : {RW'(in_data.row), CW'(in_data.col)};
  end

  // Table port: previous-row read on load, write-back, then four corner reads
  always_comb begin
    sum_we    = 1'b0;
    sum_re    = 1'b0;
    sum_wdata = sum_rd + SUM_W'(row_sum_r);
    sum_addr  = {load_row_r - RW'(1), load_col_r};
    zero_nxt  = (load_row_r == '0);
    case (state_r)
      ST_IDLE: begin
        sum_re = ld_accept;
      end
      ST_LD_WR: begin
        sum_we   = 1'b1;
        sum_addr = {load_row_r, load_col_r};
      end
      ST_Q_RD0, ST_Q_RD1, ST_Q_RD2, ST_Q_RD3: begin
        sum_re   = 1'b1;
        sum_addr = {cy - RW'(1), cx - CW'(1)};
        zero_nxt = (cy == '0) || (cx == '0);
      end
      default: ;
    endcase
  end

  // Next state, load position and result register
  always_comb begin
    state_nxt     = state_r;
    load_col_nxt  = load_col_r;
    load_row_nxt  = load_row_r;
    row_sum_nxt   = row_sum_r;
    complete_nxt  = complete_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    out_data_nxt.out_pixel = PIX_DARK;
    out_data_nxt.status    = status_r;
    if (status_r == STAT_OK && !(RHS_W'(lhs) < rhs_r)) begin
      out_data_nxt.out_pixel = PIX_LIGHT;
    end
    case (state_r)
      ST_IDLE: begin
        if (cfg.restart) begin
          load_col_nxt = '0;
          load_row_nxt = '0;
          row_sum_nxt  = '0;
          complete_nxt = 1'b0;
        end else if (ld_accept) begin
          row_sum_nxt  = ((load_col_r == '0) ? '0 : row_sum_r) + RSW'(in_data.pixel);
          complete_nxt = 1'b0;
          state_nxt    = ST_LD_WR;
        end else if (q_accept) begin
          state_nxt = (status_nxt == STAT_OK) ? ST_Q_RD0 : ST_OUT;
        end
      end
      ST_LD_WR: begin
        if (col_last) begin
          load_col_nxt = '0;
          if (row_last) begin
            load_row_nxt = '0;
            complete_nxt = 1'b1;
          end else begin
            load_row_nxt = load_row_r + RW'(1);
          end
        end else begin
          load_col_nxt = load_col_r + CW'(1);
        end
        state_nxt = ST_IDLE;
      end
      ST_Q_RD0: state_nxt = ST_Q_RD1;
      ST_Q_RD1: state_nxt = ST_Q_RD2;
      ST_Q_RD2: state_nxt = ST_Q_RD3;
      ST_Q_RD3: state_nxt = ST_Q_ACC;
      ST_Q_ACC: state_nxt = ST_Q_MUL;
      ST_Q_MUL: state_nxt = ST_OUT;
      ST_OUT: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      load_col_r  <= '0;
      load_row_r  <= '0;
      row_sum_r   <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_col_r  <= load_col_nxt;
      load_row_r  <= load_row_nxt;
      row_sum_r   <= row_sum_nxt;
      complete_r  <= complete_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Query datapath: window sum, pixel times count, sum times scale
  always_ff @(posedge clk) begin
    zero_r <= zero_nxt;
    if (q_accept) begin
      status_r <= status_nxt;
      qx1_r    <= CW'(x1);
      qx2_r    <= CW'(x2);
      qy1_r    <= RW'(y1);
      qy2_r    <= RW'(y2);
    end
    case (state_r)
      ST_Q_RD0: cnt_r <= CNT_W'(span_x) * CNT_W'(span_y);
      ST_Q_RD1: begin
        acc_r  <= sum_rd;
        prod_r <= PROD_W'(pix_rdata) * PROD_W'(cnt_r);
      end
      ST_Q_RD2: acc_r <= acc_r - sum_rd;
      ST_Q_RD3: acc_r <= acc_r - sum_rd;
      ST_Q_ACC: acc_r <= acc_r + sum_rd;
      ST_Q_MUL: rhs_r <= RHS_W'(acc_r) * RHS_W'(cfg.scale);
      default: ;
    endcase
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Take input only in the idle state, and close it while a dimension write restarts loading
  assign in_ready  = (state_r == ST_IDLE) && !cfg.restart;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/adaptive_integral_threshold_top.sv =====
// Channel   Handshake               Beat contents
// in_       in_valid / in_ready     op, pixel, col, row (in_item_t)
// out_      out_valid / out_ready   out_pixel, status (out_item_t)
// cfg_      APB psel/penable/pready width, height, threshold scale
//
// A load does one previous-row table read, then the table write-back.
// A query inside a complete image reads the four window corners through the
// single table port, one per cycle, then runs the last corner add,
// the scale multiply and the result stage.
// A query that only reports a status goes straight to the result stage.
// Reset is synchronous; the table border is forced to zero in logic, so no
// clearing pass runs. A stalled result holds the block in its output state.
`include "assert_macros.svh"

module adaptive_integral_threshold_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ait_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ait_pkg::out_item_t         out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ait_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [ait_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [ait_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ait_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned AW = CW + RW;

  cfg_t             cfg;
  logic [AW-1:0]    pix_addr;
  logic             pix_we;
  logic             pix_re;
  logic [PIX_W-1:0] pix_wdata;
  logic [PIX_W-1:0] pix_rdata;
  logic [AW-1:0]    sum_addr;
  logic             sum_we;
  logic             sum_re;
  logic [SUM_W-1:0] sum_wdata;
  logic [SUM_W-1:0] sum_rdata;

  ait_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ait_store #(
    .AW (AW)
  ) u_store (
    .clk       (clk),
    .pix_addr  (pix_addr),
    .pix_we    (pix_we),
    .pix_re    (pix_re),
    .pix_wdata (pix_wdata),
    .pix_rdata (pix_rdata),
    .sum_addr  (sum_addr),
    .sum_we    (sum_we),
    .sum_re    (sum_re),
    .sum_wdata (sum_wdata),
    .sum_rdata (sum_rdata)
  );

  ait_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg       (cfg),
    .pix_addr  (pix_addr),
    .pix_we    (pix_we),
    .pix_re    (pix_re),
    .pix_wdata (pix_wdata),
    .pix_rdata (pix_rdata),
    .sum_addr  (sum_addr),
    .sum_we    (sum_we),
    .sum_re    (sum_re),
    .sum_wdata (sum_wdata),
    .sum_rdata (sum_rdata)
  );

  // Results are binary
  `AIT_ASSERT_SAME(a_out_binary, out_valid, out_data.out_pixel == PIX_DARK || out_data.out_pixel == PIX_LIGHT)
  // A status result always carries a dark pixel
  `AIT_ASSERT_SAME(a_status_dark, out_valid && out_data.status != STAT_OK, out_data.out_pixel == PIX_DARK)
  // One item at a time: an accepted beat closes the input
  `AIT_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

endmodule
